/* rtl/fcbs_pkg.sv */
// ----------------------------------------------------------------------------
// fcbs_pkg: shared constants and types for the frustum cull block
// Plane register layout, default parameters and the per-cell control word.
// ----------------------------------------------------------------------------
package fcbs_pkg;

  localparam int PLANE_COUNT_DEF = 6;
  localparam int COORD_WIDTH_DEF = 24;

  // register file: six planes of 64 bits
  localparam int REG_COUNT = 6;
  localparam int PLANE_W   = 64;
  localparam int REG_IDX_W = 3;

  // plane packing: nx, ny, nz Q1.10, then offset Q19.8
  localparam int NORM_W   = 12;
  localparam int OFF_LSB  = 36;
  localparam int OFF_W    = 28;
  localparam int OFF_SHL  = 10;   // aligns Q19.8 offset to the Q.18 product scale

  localparam logic [REG_IDX_W-1:0] REG_LEFT   = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_RIGHT  = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_BOTTOM = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_TOP    = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_NEAR   = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_FAR    = 3'd5;

  localparam logic MODE_BOX    = 1'b0;
  localparam logic MODE_SPHERE = 1'b1;

  // control word handed from cell to cell
  typedef struct packed {
    logic valid;
    logic vis;
  } fcbs_ctl_t;

endpackage

/* rtl/fcbs_cell.sv */
// ----------------------------------------------------------------------------
// fcbs_cell: one plane test in the culling chain
// Stage 1 picks the test point and forms the three products and the bias;
// stage 2 sums them and clears the visible flag on a negative distance.
// ----------------------------------------------------------------------------
module fcbs_cell
  import fcbs_pkg::*;
#(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic [PLANE_W-1:0]        plane,
  input  fcbs_ctl_t                 ctl_in,
  input  logic [10*COORD_WIDTH-1:0] pay_in,
  output fcbs_ctl_t                 ctl_out,
  output logic [10*COORD_WIDTH-1:0] pay_out
);

  localparam int CW     = COORD_WIDTH;
  localparam int PAY_W  = 10 * CW;
  localparam int PROD_W = CW + NORM_W;
  localparam int BASE_W = (PROD_W > OFF_W + OFF_SHL) ? PROD_W : OFF_W + OFF_SHL;
  localparam int DIST_W = BASE_W + 3;

  // payload layout: {mode, radius, center, hi, lo}, x in the low slot
  localparam int LO_LSB   = 0;
  localparam int HI_LSB   = 3 * CW;
  localparam int CTR_LSB  = 6 * CW;
  localparam int RAD_LSB  = 9 * CW;
  localparam int MODE_BIT = 10 * CW - 1;

  logic signed [NORM_W-1:0] nrm [3];
  logic signed [CW-1:0]     pt  [3];
  logic signed [PROD_W-1:0] prod [3];
  logic signed [OFF_W-1:0]  off;
  logic [CW-2:0]            rad;
  logic                     mode;
  logic signed [DIST_W-1:0] bias;

  // stage 1 registers
  fcbs_ctl_t                ctl1;
  logic [PAY_W-1:0]         pay1;
  logic signed [PROD_W-1:0] prod1 [3];
  logic signed [DIST_W-1:0] bias1;

  logic signed [DIST_W-1:0] dsum;

  always_comb begin
    mode = pay_in[MODE_BIT];
    rad  = pay_in[RAD_LSB +: CW-1];
    off  = $signed(plane[OFF_LSB +: OFF_W]);
    for (int k = 0; k < 3; k++) begin
      nrm[k] = $signed(plane[NORM_W*k +: NORM_W]);
      if (mode == MODE_SPHERE) begin
        pt[k] = $signed(pay_in[CTR_LSB + CW*k +: CW]);
      end else if (nrm[k][NORM_W-1]) begin
        // negative normal component: far corner is on the low side
        pt[k] = $signed(pay_in[LO_LSB + CW*k +: CW]);
      end else begin
        pt[k] = $signed(pay_in[HI_LSB + CW*k +: CW]);
      end
      prod[k] = PROD_W'(nrm[k]) * PROD_W'(pt[k]);
    end
    // sphere: dist < -r  <=>  dist + r < 0
    bias = {{(DIST_W-OFF_W-OFF_SHL){off[OFF_W-1]}}, off, {OFF_SHL{1'b0}}};
    if (mode == MODE_SPHERE) begin
      bias = bias + $signed({{(DIST_W-CW+1-OFF_SHL){1'b0}}, rad, {OFF_SHL{1'b0}}});
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl1 <= '0;
    end else begin
      ctl1 <= ctl_in;
    end
  end

  always_ff @(posedge clk) begin
    pay1  <= pay_in;
    bias1 <= bias;
    for (int k = 0; k < 3; k++) begin
      prod1[k] <= prod[k];
    end
  end

  assign dsum = DIST_W'(prod1[0]) + DIST_W'(prod1[1]) + DIST_W'(prod1[2]) + bias1;

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_out <= '0;
    end else begin
      ctl_out.valid <= ctl1.valid;
      ctl_out.vis   <= ctl1.vis & ~dsum[DIST_W-1];
    end
  end

  always_ff @(posedge clk) begin
    pay_out <= pay1;
  end

endmodule

/* rtl/frustum_cull_box_sphere.sv */
// ----------------------------------------------------------------------------
// frustum_cull_box_sphere: box / sphere test against the frustum planes
// A chain of plane cells; each item walks the chain and leaves with its
// visible flag.
// ----------------------------------------------------------------------------
//   port group          dir  handshake            payload
//   start / busy        in   start & !busy        mode, box_lo_*, box_hi_*,
//                                                  center_*, radius
//   done                out  one-cycle strobe     visible
//   wr_en               in   wr_en                wr_index, wr_data
//
// One item per clock; busy stays low.
// Each plane cell has a multiply stage and a sum/compare stage.
// Synchronous reset clears the planes to zero and drops items in flight.
// Results cannot be stalled; done is high for exactly one cycle per item.
// ----------------------------------------------------------------------------
module frustum_cull_box_sphere
  import fcbs_pkg::*;
#(
  parameter int PLANE_COUNT = PLANE_COUNT_DEF,
  parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic                          mode,
  input  logic signed [COORD_WIDTH-1:0] box_lo_x,
  input  logic signed [COORD_WIDTH-1:0] box_lo_y,
  input  logic signed [COORD_WIDTH-1:0] box_lo_z,
  input  logic signed [COORD_WIDTH-1:0] box_hi_x,
  input  logic signed [COORD_WIDTH-1:0] box_hi_y,
  input  logic signed [COORD_WIDTH-1:0] box_hi_z,
  input  logic signed [COORD_WIDTH-1:0] center_x,
  input  logic signed [COORD_WIDTH-1:0] center_y,
  input  logic signed [COORD_WIDTH-1:0] center_z,
  input  logic        [COORD_WIDTH-2:0] radius,
  output logic                          done,
  output logic                          visible,
  input  logic                          wr_en,
  input  logic [REG_IDX_W-1:0]          wr_index,
  input  logic [PLANE_W-1:0]            wr_data
);

  localparam int PAY_W = 10 * COORD_WIDTH;

  logic [PLANE_W-1:0] plane_reg [REG_COUNT];

  fcbs_ctl_t        ctl_c [PLANE_COUNT+1];
  logic [PAY_W-1:0] pay_c [PLANE_COUNT];

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < REG_COUNT; i++) begin
        plane_reg[i] <= '0;
      end
    end else if (wr_en && (wr_index < REG_IDX_W'(REG_COUNT))) begin
      plane_reg[wr_index] <= wr_data;
    end
  end

  assign ctl_c[0].valid = start & ~busy;
  assign ctl_c[0].vis   = 1'b1;
  assign pay_c[0] = {mode, radius, center_z, center_y, center_x,
                     box_hi_z, box_hi_y, box_hi_x, box_lo_z, box_lo_y, box_lo_x};

  for (genvar i = 0; i < PLANE_COUNT; i++) begin : g_cell
    logic [PLANE_W-1:0] plane;

    // slots past the register file hold a zero plane, which never rejects
    if (i < REG_COUNT) begin : g_reg
      assign plane = plane_reg[i];
    end else begin : g_zero
      assign plane = '0;
    end

    if (i == PLANE_COUNT - 1) begin : g_last
      fcbs_cell #(.COORD_WIDTH(COORD_WIDTH)) u_cell (
        .clk     (clk),
        .rst     (rst),
        .plane   (plane),
        .ctl_in  (ctl_c[i]),
        .pay_in  (pay_c[i]),
        .ctl_out (ctl_c[i+1]),
        .pay_out ()
      );
    end else begin : g_mid
      fcbs_cell #(.COORD_WIDTH(COORD_WIDTH)) u_cell (
        .clk     (clk),
        .rst     (rst),
        .plane   (plane),
        .ctl_in  (ctl_c[i]),
        .pay_in  (pay_c[i]),
        .ctl_out (ctl_c[i+1]),
        .pay_out (pay_c[i+1])
      );
    end
  end

  assign done    = ctl_c[PLANE_COUNT].valid;
  assign visible = ctl_c[PLANE_COUNT].vis;

endmodule

/* rtl/fcbs_chk.sv */
// ----------------------------------------------------------------------------
// fcbs_chk: port-level checks for the frustum cull block
// Watches the command, result and write ports; bound to the top level.
// ----------------------------------------------------------------------------
module fcbs_chk
  import fcbs_pkg::*;
#(
  parameter int PLANE_COUNT = PLANE_COUNT_DEF
) (
  input logic                 clk,
  input logic                 rst,
  input logic                 start,
  input logic                 busy,
  input logic                 done,
  input logic                 visible,
  input logic                 wr_en,
  input logic [REG_IDX_W-1:0] wr_index,
  input logic [PLANE_W-1:0]   wr_data
);

  localparam int LATENCY = 2 * PLANE_COUNT;
  localparam int CNT_W   = $clog2(LATENCY + 1);

  logic [CNT_W-1:0] since_rst;
  logic             planes_zero;

  always_ff @(posedge clk) begin
    if (rst) begin
      since_rst <= '0;
    end else if (since_rst != CNT_W'(LATENCY)) begin
      since_rst <= since_rst + 1'b1;
    end
  end

  // all planes still zero: nothing can be culled
  always_ff @(posedge clk) begin
    if (rst) begin
      planes_zero <= 1'b1;
    end else if (wr_en && (wr_index < REG_IDX_W'(REG_COUNT)) && (wr_data != '0)) begin
      planes_zero <= 1'b0;
    end
  end

  a_no_stall: assert property (@(posedge clk) disable iff (rst) !busy)
    else $error("busy raised");

  a_reset_flush: assert property (@(posedge clk) rst |=> !done)
    else $error("result strobe right after reset");

  a_one_result_per_item: assert property (@(posedge clk) disable iff (rst)
    (since_rst == CNT_W'(LATENCY)) |-> (done == $past(start && !busy, LATENCY)))
    else $error("result strobe does not match accepted item");

  a_zero_planes_pass: assert property (@(posedge clk) disable iff (rst)
    (done && planes_zero) |-> visible)
    else $error("item culled with all planes zero");

endmodule

bind frustum_cull_box_sphere fcbs_chk #(.PLANE_COUNT(PLANE_COUNT)) u_fcbs_chk (
  .clk      (clk),
  .rst      (rst),
  .start    (start),
  .busy     (busy),
  .done     (done),
  .visible  (visible),
  .wr_en    (wr_en),
  .wr_index (wr_index),
  .wr_data  (wr_data)
);
